[rtl/core/per_layer_lru_slot_bank_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the per-layer LRU slot bank
// Shared shorthands for the concurrent checks on the block's ports.
// ---------------------------------------------------------------------------
`ifndef PER_LAYER_LRU_SLOT_BANK_MACROS_SVH
`define PER_LAYER_LRU_SLOT_BANK_MACROS_SVH

// same-cycle implication, quiet during reset
`define PLSB_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("plsb check failed");

// next-cycle implication, also checked across reset
`define PLSB_ASSERT_NXT(lbl, clk, a, b) \
   lbl: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("plsb check failed");

`endif

[rtl/core/plsb_pkg.sv]
// ---------------------------------------------------------------------------
// plsb_pkg
// Fixed widths, status codes and shared types of the slot bank.
// ---------------------------------------------------------------------------
`default_nettype none

package plsb_pkg;

   localparam int LAYER_W      = 6;
   localparam int EXPERT_W     = 10;
   localparam int SLOT_W       = 3;
   localparam int POS_W        = 3;
   localparam int STATUS_W     = 3;
   localparam int LAYER_CNT_W  = 7;
   localparam int BANK_SIZE_W  = 4;
   localparam int CSR_DATA_W   = 7;
   localparam int CSR_IDX_W    = 1;

   localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISS   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_COMMIT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DROP   = 3'd4;

   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_FILL   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_CNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BANK_SIZE = 1'd1;

   typedef struct packed {
      logic rd;
      logic wr;
      logic clr;
   } store_ctrl_type;

endpackage

`default_nettype wire

[rtl/core/plsb_slot_cmp.sv]
// ---------------------------------------------------------------------------
// plsb_slot_cmp
// Shared slot compare unit: expert id match and stamp order.
// ---------------------------------------------------------------------------
`default_nettype none

module plsb_slot_cmp #(
   parameter int EB = 10,
   parameter int SB = 32
) (
   input  logic [EB-1:0] id_a,
   input  logic [EB-1:0] id_b,
   input  logic [SB-1:0] st_a,
   input  logic [SB-1:0] st_b,
   output logic          id_eq,
   output logic          st_lt
);

   assign id_eq = (id_a == id_b);
   assign st_lt = (st_a < st_b);

endmodule

`default_nettype wire

[rtl/core/plsb_row_store.sv]
// ---------------------------------------------------------------------------
// plsb_row_store
// One row per layer: owners, valid bits, stamps and counter. A row flag
// marks rows written since the last clear; unmarked rows read with rok low.
// ---------------------------------------------------------------------------
`default_nettype none

module plsb_row_store import plsb_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  store_ctrl_type ctrl,
   input  logic [AW-1:0]  addr,
   input  logic [DW-1:0]  wdata,
   output logic [DW-1:0]  rdata,
   output logic           rok
);

   logic [DW-1:0]    row_mem [DEPTH];
   logic [DW-1:0]    rdata_ff;
   logic             rok_ff;
   logic             rok_in;
   logic [DEPTH-1:0] row_ok_ff;
   logic [DEPTH-1:0] row_ok_in;

   always_ff @(posedge clock) begin
      if (ctrl.wr) begin
         row_mem[addr] <= wdata;
      end
      if (ctrl.rd) begin
         rdata_ff <= row_mem[addr];
      end
   end

   always_comb begin
      row_ok_in = row_ok_ff;
      if (ctrl.clr) begin
         row_ok_in = '0;
      end else if (ctrl.wr) begin
         row_ok_in[addr] = 1'b1;
      end
      rok_in = ctrl.rd ? row_ok_ff[addr] : rok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ok_ff <= '0;
         rok_ff    <= 1'b0;
      end else begin
         row_ok_ff <= row_ok_in;
         rok_ff    <= rok_in;
      end
   end

   assign rdata = rdata_ff;
   assign rok   = rok_ff;

endmodule

`default_nettype wire

[rtl/core/per_layer_lru_slot_bank.sv]
// ---------------------------------------------------------------------------
// per_layer_lru_slot_bank
// Per-layer cache directory of expert ids with LRU slot replacement.
// ---------------------------------------------------------------------------
// Usage:
//  - Pulse start with the req_ fields while busy is low to hand in a word.
//    Lookups are buffered until one with req_batch_last; that word runs the
//    batch and yields one result per buffered lookup. A fill-done word
//    commits or drops the owner of a slot and yields one result.
//  - Results appear on the rsp_ ports for one cycle with rsp_valid high; the
//    receiver cannot stall, so every result is taken as shown.
//  - A buffered (non-final) lookup is taken while busy stays low.
//  - A fill-done runs row read, load, update, then write with result.
//    A rejected fill or batch answers in the next cycle with status bad.
//  - A batch of k lookups on a bank of n slots runs in order: one shared
//    compare unit walks the slots, one per cycle, for the hit search of each
//    lookup and for the victim search of each miss, then the row is written
//    back and the k results leave one per cycle.
//  - Config: csr_we writes register csr_index (0 layer count, 1 bank_size).
//    Writing bank_size empties every layer row and drops a pending batch.
//  - Reset: layer count 64, bank_size 0 (bank disabled), all rows empty.
//    The clear is a flag per row, so no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module per_layer_lru_slot_bank import plsb_pkg::*; #(
   parameter int MAX_LAYERS  = 64,
   parameter int BANK_SLOTS  = 8,
   parameter int EXPERT_BITS = 10,
   parameter int STAMP_BITS  = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_type,
   input  logic [LAYER_W-1:0]      req_layer,
   input  logic [EXPERT_W-1:0]     req_expert_id,
   input  logic [SLOT_W-1:0]       req_fill_slot,
   input  logic                    req_fill_ok,
   input  logic                    req_batch_last,
   output logic                    rsp_valid,
   output logic [POS_W-1:0]        rsp_position,
   output logic [SLOT_W-1:0]       rsp_slot_index,
   output logic                    rsp_miss,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic                    rsp_result_last,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SW = (BANK_SLOTS > 1) ? $clog2(BANK_SLOTS) : 1;
   localparam int CW = $clog2(BANK_SLOTS + 1);
   localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int EB = EXPERT_BITS;
   localparam int SB = STAMP_BITS;
   localparam int DW = SB + BANK_SLOTS * (SB + 1 + EB);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_HIT   = 3'd2;
   localparam logic [2:0] S_MISS  = 3'd3;
   localparam logic [2:0] S_FILL  = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   // control
   logic [2:0]              state_ff, state_in;
   logic [LAYER_CNT_W-1:0]  nl_ff, nl_in;
   logic [BANK_SIZE_W-1:0]  bsz_ff, bsz_in;
   logic [CW-1:0]           pcount_ff, pcount_in;
   logic [LAYER_W-1:0]      player_ff, player_in;
   logic                    perr_ff, perr_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload
   logic [BANK_SLOTS-1:0][EB-1:0] pend_ff, pend_in;
   logic [BANK_SLOTS-1:0][EB-1:0] own_ff, own_in;
   logic [BANK_SLOTS-1:0]         vld_ff, vld_in;
   logic [BANK_SLOTS-1:0][SB-1:0] stp_ff, stp_in;
   logic [SB-1:0]                 cnt_ff, cnt_in;
   logic [BANK_SLOTS-1:0]         prot_ff, prot_in;
   logic [BANK_SLOTS-1:0]         resv_ff, resv_in;
   logic [BANK_SLOTS-1:0][SW-1:0] slot_of_ff, slot_of_in;
   logic [BANK_SLOTS-1:0]         miss_of_ff, miss_of_in;
   logic [SW-1:0]                 i_ff, i_in;
   logic [SW-1:0]                 s_ff, s_in;
   logic                          ffnd_ff, ffnd_in;
   logic [SW-1:0]                 free_ff, free_in;
   logic                          cfnd_ff, cfnd_in;
   logic [SW-1:0]                 best_ff, best_in;
   logic [LW-1:0]                 lay_ff, lay_in;
   logic                          op_fill_ff, op_fill_in;
   logic [SW-1:0]                 fs_ff, fs_in;
   logic [EB-1:0]                 fid_ff, fid_in;
   logic                          fok_ff, fok_in;
   logic [POS_W-1:0]              rsp_pos_ff, rsp_pos_in;
   logic [SLOT_W-1:0]             rsp_slot_ff, rsp_slot_in;
   logic                          rsp_miss_ff, rsp_miss_in;
   logic [STATUS_W-1:0]           rsp_status_ff, rsp_status_in;
   logic                          rsp_last_ff, rsp_last_in;

   // store port
   store_ctrl_type st_ctrl;
   logic [LW-1:0]  st_addr;
   logic [DW-1:0]  st_rdata;
   logic           st_rok;
   logic [DW-1:0]  row_l;

   logic [BANK_SLOTS-1:0][EB-1:0] own_l;
   logic [BANK_SLOTS-1:0]         vld_l;
   logic [BANK_SLOTS-1:0][SB-1:0] stp_l;
   logic [SB-1:0]                 cnt_l;

   // shared compare unit
   logic id_eq;
   logic st_lt;

   // derived values
   logic [7:0]    n8;
   logic [7:0]    bsz8;
   logic [15:0]   limit16;
   logic [15:0]   lay16;
   logic [31:0]   eid32;
   logic [EB-1:0] eid;
   logic [7:0]    fs8;
   logic          fill_bad;
   logic          pfull;
   logic [CW-1:0] pcount_new;
   logic [LAYER_W-1:0] layer_new;
   logic [15:0]   layer_new16;
   logic          perr_new;
   logic          batch_bad;
   logic          s_last;
   logic          i_last;
   logic [SB-1:0] cnt_sat;
   logic          elig;
   logic          isfree;
   logic          take_c;
   logic          ffnd_now;
   logic [SW-1:0] free_now;
   logic          cfnd_now;
   logic [SW-1:0] best_now;
   logic [SW-1:0] choice;

   plsb_row_store #(
      .DEPTH (MAX_LAYERS),
      .AW    (LW),
      .DW    (DW)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .ctrl  (st_ctrl),
      .addr  (st_addr),
      .wdata ({cnt_ff, stp_ff, vld_ff, own_ff}),
      .rdata (st_rdata),
      .rok   (st_rok)
   );

   plsb_slot_cmp #(
      .EB (EB),
      .SB (SB)
   ) u_cmp (
      .id_a  (own_ff[s_ff]),
      .id_b  (pend_ff[i_ff]),
      .st_a  (stp_ff[s_ff]),
      .st_b  (stp_ff[best_ff]),
      .id_eq (id_eq),
      .st_lt (st_lt)
   );

   // a row never written since the last clear reads as empty
   assign row_l = st_rok ? st_rdata : '0;
   assign {cnt_l, stp_l, vld_l, own_l} = row_l;

   assign bsz8    = 8'(bsz_ff);
   assign n8      = (bsz8 > 8'(BANK_SLOTS)) ? 8'(BANK_SLOTS) : bsz8;
   assign limit16 = (16'(nl_ff) > 16'(MAX_LAYERS)) ? 16'(MAX_LAYERS) : 16'(nl_ff);
   assign lay16   = 16'(req_layer);
   assign eid32   = 32'(req_expert_id);
   assign eid     = eid32[EB-1:0];
   assign fs8     = 8'(req_fill_slot);

   assign fill_bad = (n8 == 8'd0) || (lay16 >= limit16) || (fs8 >= n8);

   assign pfull       = (8'(pcount_ff) >= 8'(BANK_SLOTS));
   assign pcount_new  = pfull ? pcount_ff : pcount_ff + 1'b1;
   assign layer_new   = (pcount_ff == '0) ? req_layer : player_ff;
   assign layer_new16 = 16'(layer_new);
   assign perr_new    = perr_ff | pfull;
   assign batch_bad   = perr_new || (n8 == 8'd0) || (layer_new16 >= limit16)
                        || (8'(pcount_new) > n8);

   assign s_last  = ((8'(s_ff) + 8'd1) >= n8);
   assign i_last  = ((8'(i_ff) + 8'd1) >= 8'(pcount_ff));
   assign cnt_sat = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;

   // victim search terms for slot s
   assign elig     = !prot_ff[s_ff] && !resv_ff[s_ff];
   assign isfree   = !resv_ff[s_ff] && !vld_ff[s_ff];
   assign take_c   = elig && (!cfnd_ff || st_lt);
   assign ffnd_now = ffnd_ff | isfree;
   assign free_now = ffnd_ff ? free_ff : s_ff;
   assign cfnd_now = cfnd_ff | elig;
   assign best_now = take_c ? s_ff : best_ff;
   assign choice   = ffnd_now ? free_now : (cfnd_now ? best_now : '0);

   always_comb begin
      state_in      = state_ff;
      nl_in         = nl_ff;
      bsz_in        = bsz_ff;
      pcount_in     = pcount_ff;
      player_in     = player_ff;
      perr_in       = perr_ff;
      pend_in       = pend_ff;
      own_in        = own_ff;
      vld_in        = vld_ff;
      stp_in        = stp_ff;
      cnt_in        = cnt_ff;
      prot_in       = prot_ff;
      resv_in       = resv_ff;
      slot_of_in    = slot_of_ff;
      miss_of_in    = miss_of_ff;
      i_in          = i_ff;
      s_in          = s_ff;
      ffnd_in       = ffnd_ff;
      free_in       = free_ff;
      cfnd_in       = cfnd_ff;
      best_in       = best_ff;
      lay_in        = lay_ff;
      op_fill_in    = op_fill_ff;
      fs_in         = fs_ff;
      fid_in        = fid_ff;
      fok_in        = fok_ff;
      rsp_valid_in  = 1'b0;
      rsp_pos_in    = rsp_pos_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_miss_in   = rsp_miss_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      st_ctrl       = '0;
      st_addr       = lay_ff;

      case (state_ff)
         S_IDLE: begin
            if (csr_we) begin
               if (csr_index == CSR_LAYER_CNT) begin
                  nl_in = csr_wdata;
               end else begin
                  bsz_in      = csr_wdata[BANK_SIZE_W-1:0];
                  st_ctrl.clr = 1'b1;
                  pcount_in   = '0;
                  player_in   = '0;
                  perr_in     = 1'b0;
               end
            end
            if (start) begin
               if (req_type == REQ_FILL) begin
                  if (fill_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_pos_in    = '0;
                     rsp_slot_in   = '0;
                     rsp_miss_in   = 1'b0;
                     rsp_status_in = ST_BAD;
                     rsp_last_in   = 1'b1;
                  end else begin
                     lay_in      = lay16[LW-1:0];
                     st_addr     = lay16[LW-1:0];
                     st_ctrl.rd  = 1'b1;
                     op_fill_in  = 1'b1;
                     fs_in       = fs8[SW-1:0];
                     fid_in      = eid;
                     fok_in      = req_fill_ok;
                     state_in    = S_LOAD;
                  end
               end else begin
                  // buffer the lookup, then run the batch on its last word
                  if (!pfull) begin
                     pend_in[pcount_ff[SW-1:0]] = eid;
                  end
                  if (!req_batch_last) begin
                     pcount_in = pcount_new;
                     player_in = layer_new;
                     perr_in   = perr_new;
                  end else if (batch_bad) begin
                     pcount_in     = '0;
                     player_in     = '0;
                     perr_in       = 1'b0;
                     rsp_valid_in  = 1'b1;
                     rsp_pos_in    = '0;
                     rsp_slot_in   = '0;
                     rsp_miss_in   = 1'b0;
                     rsp_status_in = ST_BAD;
                     rsp_last_in   = 1'b1;
                  end else begin
                     pcount_in  = pcount_new;
                     player_in  = layer_new;
                     perr_in    = perr_new;
                     lay_in     = layer_new16[LW-1:0];
                     st_addr    = layer_new16[LW-1:0];
                     st_ctrl.rd = 1'b1;
                     op_fill_in = 1'b0;
                     state_in   = S_LOAD;
                  end
               end
            end
         end

         S_LOAD: begin
            own_in  = own_l;
            vld_in  = vld_l;
            stp_in  = stp_l;
            cnt_in  = cnt_l;
            i_in    = '0;
            s_in    = '0;
            prot_in = '0;
            resv_in = '0;
            state_in = op_fill_ff ? S_FILL : S_HIT;
         end

         S_HIT: begin
            // one slot of one lookup per cycle; first valid match wins
            if (vld_ff[s_ff] && id_eq) begin
               miss_of_in[i_ff] = 1'b0;
               slot_of_in[i_ff] = s_ff;
               prot_in[s_ff]    = 1'b1;
               cnt_in           = cnt_sat;
               stp_in[s_ff]     = cnt_sat;
            end else if (s_last) begin
               miss_of_in[i_ff] = 1'b1;
               slot_of_in[i_ff] = '0;
            end
            if ((vld_ff[s_ff] && id_eq) || s_last) begin
               s_in = '0;
               if (i_last) begin
                  i_in     = '0;
                  ffnd_in  = 1'b0;
                  cfnd_in  = 1'b0;
                  best_in  = '0;
                  free_in  = '0;
                  state_in = S_MISS;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               s_in = s_ff + 1'b1;
            end
         end

         S_MISS: begin
            if (!miss_of_ff[i_ff] || s_last) begin
               if (miss_of_ff[i_ff]) begin
                  resv_in[choice]    = 1'b1;
                  slot_of_in[i_ff]   = choice;
               end
               s_in    = '0;
               ffnd_in = 1'b0;
               cfnd_in = 1'b0;
               best_in = '0;
               free_in = '0;
               if (i_last) begin
                  state_in = S_WRITE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               // track first free slot and least recent eligible slot
               ffnd_in = ffnd_now;
               free_in = free_now;
               cfnd_in = cfnd_now;
               best_in = best_now;
               s_in    = s_ff + 1'b1;
            end
         end

         S_FILL: begin
            if (fok_ff) begin
               own_in[fs_ff] = fid_ff;
               vld_in[fs_ff] = 1'b1;
               cnt_in        = cnt_sat;
               stp_in[fs_ff] = cnt_sat;
            end else begin
               vld_in[fs_ff] = 1'b0;
            end
            state_in = S_WRITE;
         end

         S_WRITE: begin
            st_ctrl.wr = 1'b1;
            if (op_fill_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_pos_in    = '0;
               rsp_slot_in   = SLOT_W'(fs_ff);
               rsp_miss_in   = 1'b0;
               rsp_status_in = fok_ff ? ST_COMMIT : ST_DROP;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               i_in     = '0;
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_pos_in    = POS_W'(i_ff);
            rsp_slot_in   = SLOT_W'(slot_of_ff[i_ff]);
            rsp_miss_in   = miss_of_ff[i_ff];
            rsp_status_in = miss_of_ff[i_ff] ? ST_MISS : ST_HIT;
            rsp_last_in   = i_last;
            if (i_last) begin
               pcount_in = '0;
               player_in = '0;
               perr_in   = 1'b0;
               state_in  = S_IDLE;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nl_ff        <= 7'd64;
         bsz_ff       <= '0;
         pcount_ff    <= '0;
         player_ff    <= '0;
         perr_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nl_ff        <= nl_in;
         bsz_ff       <= bsz_in;
         pcount_ff    <= pcount_in;
         player_ff    <= player_in;
         perr_ff      <= perr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff       <= pend_in;
      own_ff        <= own_in;
      vld_ff        <= vld_in;
      stp_ff        <= stp_in;
      cnt_ff        <= cnt_in;
      prot_ff       <= prot_in;
      resv_ff       <= resv_in;
      slot_of_ff    <= slot_of_in;
      miss_of_ff    <= miss_of_in;
      i_ff          <= i_in;
      s_ff          <= s_in;
      ffnd_ff       <= ffnd_in;
      free_ff       <= free_in;
      cfnd_ff       <= cfnd_in;
      best_ff       <= best_in;
      lay_ff        <= lay_in;
      op_fill_ff    <= op_fill_in;
      fs_ff         <= fs_in;
      fid_ff        <= fid_in;
      fok_ff        <= fok_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_miss_ff   <= rsp_miss_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_miss        = rsp_miss_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_last = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/core/plsb_checker.sv]
// ---------------------------------------------------------------------------
// plsb_checker
// Port-level checks of the slot bank, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "per_layer_lru_slot_bank_macros.svh"

module plsb_checker import plsb_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                busy,
   input logic                rsp_valid,
   input logic [POS_W-1:0]    rsp_position,
   input logic [SLOT_W-1:0]   rsp_slot_index,
   input logic                rsp_miss,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_result_last
);

   logic one_word;
   logic one_word_ok;
   logic bad_word;

   assign one_word    = rsp_valid && (rsp_status == ST_BAD || rsp_status == ST_COMMIT
                                      || rsp_status == ST_DROP);
   assign one_word_ok = rsp_result_last && (rsp_position == '0);
   assign bad_word    = rsp_valid && (rsp_status == ST_BAD);

   // miss flag agrees with the status code
   `PLSB_ASSERT_IMP(a_miss_status, clock, reset, rsp_valid, rsp_miss == (rsp_status == ST_MISS))
   // error and fill answers are single, final words at position zero
   `PLSB_ASSERT_IMP(a_single_word, clock, reset, one_word, one_word_ok)
   // an error word carries slot zero
   `PLSB_ASSERT_IMP(a_bad_slot, clock, reset, bad_word, rsp_slot_index == '0)
   // nothing pending right after reset
   `PLSB_ASSERT_NXT(a_reset_quiet, clock, reset, !rsp_valid && !busy)

endmodule

bind per_layer_lru_slot_bank plsb_checker u_plsb_checker (.*);

`default_nettype wire

[dv/tb_per_layer_lru_slot_bank.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the per-layer LRU slot bank
// Drives lookup batches and fill-done words through the start/busy command
// port, predicts every result with an in-bench model of the slot banks, and
// checks each strobed result against the oldest predicted one. Runs several
// register settings, the extremes among them, with random idle gaps.
// ---------------------------------------------------------------------------
module tb_per_layer_lru_slot_bank;
   import plsb_pkg::*;

   typedef struct {
      logic [POS_W-1:0]    pos;
      logic [SLOT_W-1:0]   slot;
      logic                miss;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_type = REQ_LOOKUP;
   logic [LAYER_W-1:0]    req_layer = '0;
   logic [EXPERT_W-1:0]   req_expert_id = '0;
   logic [SLOT_W-1:0]     req_fill_slot = '0;
   logic                  req_fill_ok = 1'b0;
   logic                  req_batch_last = 1'b0;
   logic                  rsp_valid;
   logic [POS_W-1:0]      rsp_position;
   logic [SLOT_W-1:0]     rsp_slot_index;
   logic                  rsp_miss;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_result_last;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_LAYER_CNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   per_layer_lru_slot_bank u_top (.*);

   // Shadow copy of the slot banks and of the batch being gathered.
   bit [EXPERT_W-1:0] owner_id  [64][8];
   bit                owner_vld [64][8];
   bit [31:0]         stamp_of  [64][8];
   bit [31:0]         use_ctr   [64];
   bit [EXPERT_W-1:0] batch_id  [8];
   int unsigned       batch_cnt;
   bit [LAYER_W-1:0]  batch_layer;
   bit                batch_bad;
   int unsigned       layer_cnt_reg;
   int unsigned       bank_size_reg;

   rsp_word_type expected_rsp[$];
   int        fail_cnt = 0;
   bit        quiet = 1'b0;   // long stretch without idle gaps

   initial forever #10 clock = ~clock;

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int unsigned bank_n();
      return (bank_size_reg > 8) ? 8 : bank_size_reg;
   endfunction

   function automatic int unsigned layer_lim();
      return (layer_cnt_reg > 64) ? 64 : layer_cnt_reg;
   endfunction

   function automatic void clear_banks();
      foreach (owner_vld[l, s]) begin
         owner_vld[l][s] = 1'b0;
         stamp_of[l][s]  = '0;
      end
      foreach (use_ctr[l]) use_ctr[l] = '0;
      batch_cnt = 0;
      batch_layer = '0;
      batch_bad = 1'b0;
   endfunction

   function automatic void push_rsp(int unsigned p, int unsigned s, bit m,
                                    logic [STATUS_W-1:0] st, bit l);
      rsp_word_type w;
      w.pos = p[POS_W-1:0];
      w.slot = s[SLOT_W-1:0];
      w.miss = m;
      w.status = st;
      w.last = l;
      expected_rsp.push_back(w);
   endfunction

   function automatic void bump_stamp(int unsigned lay, int unsigned s);
      if (use_ctr[lay] != 32'hFFFF_FFFF) use_ctr[lay]++;
      stamp_of[lay][s] = use_ctr[lay];
   endfunction

   // Resolve a gathered batch: hits first in request order, then victims.
   function automatic void resolve_batch();
      int unsigned n, k, lay, i, s, best;
      bit          prot[8], resv[8], miss_of[8], found;
      int unsigned slot_of[8];
      n = bank_n();
      k = batch_cnt;
      lay = 32'(batch_layer);
      if (batch_bad || n == 0 || lay >= layer_lim() || k > n || k == 0) begin
         push_rsp(0, 0, 1'b0, ST_BAD, 1'b1);
         return;
      end
      for (i = 0; i < 8; i++) begin
         prot[i] = 1'b0;
         resv[i] = 1'b0;
      end
      for (i = 0; i < k; i++) begin
         miss_of[i] = 1'b1;
         slot_of[i] = 0;
         for (s = 0; s < n; s++)
            if (owner_vld[lay][s] && owner_id[lay][s] == batch_id[i]) begin
               miss_of[i] = 1'b0;
               slot_of[i] = s;
               prot[s] = 1'b1;
               bump_stamp(lay, s);
               break;
            end
      end
      for (i = 0; i < k; i++) begin
         if (!miss_of[i]) continue;
         found = 1'b0;
         best = 0;
         // lowest free slot first
         for (s = 0; s < n && !found; s++)
            if (!resv[s] && !owner_vld[lay][s]) begin
               best = s;
               found = 1'b1;
            end
         // else oldest stamp among unprotected, unreserved; lowest on tie
         if (!found)
            for (s = 0; s < n; s++)
               if (!prot[s] && !resv[s] && (!found || stamp_of[lay][s] < stamp_of[lay][best]))
               begin
                  best = s;
                  found = 1'b1;
               end
         resv[best] = 1'b1;
         slot_of[i] = best;
      end
      for (i = 0; i < k; i++)
         push_rsp(i, slot_of[i], miss_of[i], miss_of[i] ? ST_MISS : ST_HIT, i + 1 == k);
   endfunction

   function automatic void predict_word(bit typ, int unsigned lay, int unsigned eid,
                                        int unsigned fslot, bit fok, bit last);
      if (typ == REQ_FILL) begin
         if (bank_n() == 0 || lay >= layer_lim() || fslot >= bank_n())
            push_rsp(0, 0, 1'b0, ST_BAD, 1'b1);
         else if (fok) begin
            owner_id[lay][fslot] = eid[EXPERT_W-1:0];
            owner_vld[lay][fslot] = 1'b1;
            bump_stamp(lay, fslot);
            push_rsp(0, fslot, 1'b0, ST_COMMIT, 1'b1);
         end else begin
            owner_vld[lay][fslot] = 1'b0;
            push_rsp(0, fslot, 1'b0, ST_DROP, 1'b1);
         end
         return;
      end
      if (batch_cnt == 0) batch_layer = lay[LAYER_W-1:0];
      if (batch_cnt >= 8) batch_bad = 1'b1;
      else batch_id[batch_cnt++] = eid[EXPERT_W-1:0];
      if (!last) return;
      resolve_batch();
      batch_cnt = 0;
      batch_layer = '0;
      batch_bad = 1'b0;
   endfunction

   // Hand in one word; call at a rising edge. Returns at the accepting edge
   // with start still high, so the next word follows without a gap.
   task automatic send_word(bit typ, int unsigned lay, int unsigned eid,
                            int unsigned fslot, bit fok, bit last);
      int unsigned gap;
      gap = (!quiet && $urandom_range(99) < 23) ? $urandom_range(4, 1) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= typ;
      req_layer      <= lay[LAYER_W-1:0];
      req_expert_id  <= eid[EXPERT_W-1:0];
      req_fill_slot  <= fslot[SLOT_W-1:0];
      req_fill_ok    <= fok;
      req_batch_last <= last;
      // values read right after the edge are the ones the block sampled
      do @(posedge clock); while (busy);
      predict_word(typ, lay, eid, fslot, fok, last);
   endtask

   // Drop start and hold until every predicted result has come back.
   task automatic drain();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LAYER_CNT) layer_cnt_reg = val & 7'h7F;
      else begin
         bank_size_reg = val & 4'hF;
         clear_banks();
      end
   endtask

   // Compare each strobed result with the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected result pos=%0d slot=%0d status=%0d", $realtime,
                     rsp_position, rsp_slot_index, rsp_status);
            fail_cnt++;
         end else begin
            w = expected_rsp.pop_front();
            if (rsp_position !== w.pos || rsp_slot_index !== w.slot ||
                rsp_miss !== w.miss || rsp_status !== w.status ||
                rsp_result_last !== w.last) begin
               $display("%0t: mismatch exp pos=%0d slot=%0d miss=%0d status=%0d last=%0d",
                        $realtime, w.pos, w.slot, w.miss, w.status, w.last);
               $display("%0t:          got pos=%0d slot=%0d miss=%0d status=%0d last=%0d",
                        $realtime, rsp_position, rsp_slot_index, rsp_miss, rsp_status,
                        rsp_result_last);
               fail_cnt++;
            end
         end
      end
   end

   // Disabled bank after reset: everything is rejected.
   task automatic test_reset_defaults();
      send_word(REQ_LOOKUP, 0, 3, 0, 0, 1'b1);
      send_word(REQ_FILL, 0, 3, 0, 1'b1, 1'b0);
      drain();
   endtask

   // Directed words: field extremes, every status, the bad cases of an enabled bank.
   task automatic test_directed();
      int unsigned i;
      write_reg(CSR_LAYER_CNT, 4);
      write_reg(CSR_BANK_SIZE, 4);
      send_word(REQ_FILL, 0, 0, 0, 1'b1, 1'b0);
      send_word(REQ_FILL, 0, 1023, 1, 1'b1, 1'b1);
      send_word(REQ_FILL, 0, 5, 2, 1'b1, 1'b0);
      send_word(REQ_FILL, 0, 6, 3, 1'b0, 1'b0);   // dropped fill
      send_word(REQ_FILL, 0, 6, 7, 1'b1, 1'b0);   // slot past bank size
      send_word(REQ_FILL, 63, 6, 0, 1'b1, 1'b0);  // layer past limit
      // hits plus misses, later layer field ignored
      send_word(REQ_LOOKUP, 0, 1023, 0, 0, 1'b0);
      send_word(REQ_LOOKUP, 63, 7, 0, 0, 1'b0);
      send_word(REQ_LOOKUP, 0, 5, 0, 0, 1'b0);
      send_word(REQ_LOOKUP, 0, 8, 0, 0, 1'b1);
      // batch longer than the bank
      for (i = 0; i < 5; i++) send_word(REQ_LOOKUP, 1, i, 0, 0, i == 4);
      send_word(REQ_LOOKUP, 63, 2, 0, 0, 1'b1);   // bad layer
      drain();
      write_reg(CSR_BANK_SIZE, 8);
      // overlong batch: ninth word with eight buffered
      for (i = 0; i < 9; i++) send_word(REQ_LOOKUP, 2, 1023 - i, 0, 0, i == 8);
      send_word(REQ_FILL, 3, 512, 7, 1'b1, 1'b0);
      drain();
   endtask

   // Random phase: mostly well-formed batches over a small id pool.
   task automatic test_random(int unsigned n_layers, int unsigned n_bank, int unsigned n_words);
      int unsigned sent, len, i, lay, lim, n;
      write_reg(CSR_LAYER_CNT, n_layers);
      write_reg(CSR_BANK_SIZE, n_bank);
      lim = (layer_lim() == 0) ? 1 : layer_lim();
      n = (bank_n() == 0) ? 1 : bank_n();
      sent = 0;
      while (sent < n_words) begin
         quiet = (sent > n_words / 2 && sent < n_words / 2 + 25);
         lay = ($urandom_range(9) == 0) ? $urandom_range(63)
                                        : $urandom_range((lim > 4 ? 4 : lim) - 1);
         if ($urandom_range(99) < 35) begin
            send_word(REQ_FILL, lay, $urandom_range(11), $urandom_range(n - 1 + (n < 8)),
                      $urandom_range(99) < 85, 1'($urandom_range(1)));
            sent++;
         end else begin
            len = $urandom_range(n, 1);
            if ($urandom_range(19) == 0) len = $urandom_range(10, n + 1);
            for (i = 0; i < len; i++) begin
               send_word(REQ_LOOKUP, (i == 0) ? lay : $urandom_range(63),
                         ($urandom_range(15) == 0) ? $urandom_range(1023) : $urandom_range(11),
                         $urandom_range(7), 1'($urandom_range(1)), i + 1 == len);
               sent++;
            end
         end
      end
      quiet = 1'b0;
      drain();
   endtask

   initial begin
      layer_cnt_reg = 64;
      bank_size_reg = 0;
      clear_banks();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      test_random(64, 8, 70);
      test_random(1, 1, 50);
      test_random(7, 3, 60);
      test_random(127, 15, 70);
      test_random(0, 5, 30);
      test_random(2, 6, 70);
      test_random(64, 0, 20);
      test_random(64, 8, 20);
      if (fail_cnt == 0 && expected_rsp.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
